@@ sv/three_class_call_priority_queue_unit_assert.svh @@
// Assertion macros for the three-class call priority queue unit.
`ifndef THREE_CLASS_CALL_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define THREE_CLASS_CALL_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Condition must hold in the same cycle as the trigger
`define CPQ_ASSERT_NOW(name, trig, cond) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("cpq assertion failed");

// Condition must hold in the cycle after the trigger
`define CPQ_ASSERT_NEXT(name, trig, cond) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("cpq assertion failed");

`endif

@@ sv/cpq_pkg.sv @@
// Package: payload types, request and class codes, default sizes for the call queue.
package cpq_pkg;

   // Default sizes
   localparam int CPQ_CLASS_DEPTH = 16;
   localparam int CPQ_ID_WIDTH    = 16;

   // Fixed field widths of the transactions
   localparam int CPQ_REQ_W     = 2;
   localparam int CPQ_CLASS_W   = 2;
   localparam int CPQ_CALL_ID_W = 16;
   localparam int CPQ_REMOVED_W = 5;
   localparam int CPQ_TOTAL_W   = 6;

   // Request codes
   localparam logic [CPQ_REQ_W-1:0] CPQ_REQ_APPEND  = 2'd0;
   localparam logic [CPQ_REQ_W-1:0] CPQ_REQ_SERVE   = 2'd1;
   localparam logic [CPQ_REQ_W-1:0] CPQ_REQ_DISMISS = 2'd2;

   // Class codes, lowest priority first
   localparam logic [CPQ_CLASS_W-1:0] CPQ_CLS_DATA    = 2'd0;
   localparam logic [CPQ_CLASS_W-1:0] CPQ_CLS_VOICE   = 2'd1;
   localparam logic [CPQ_CLASS_W-1:0] CPQ_CLS_EMERG   = 2'd2;
   localparam int                     CPQ_NUM_CLASSES = 3;

   typedef struct packed {
      logic [CPQ_REQ_W-1:0]     req_type;
      logic [CPQ_CLASS_W-1:0]   call_class;
      logic [CPQ_CALL_ID_W-1:0] call_id;
   } cpq_req_type;

   typedef struct packed {
      logic                     ok;
      logic [CPQ_CALL_ID_W-1:0] served_id;
      logic [CPQ_CLASS_W-1:0]   served_class;
      logic [CPQ_REMOVED_W-1:0] removed_count;
      logic [CPQ_TOTAL_W-1:0]   total_count;
   } cpq_rsp_type;

endpackage

@@ sv/three_class_call_priority_queue_unit.sv @@
// Top level: three-class call priority queue with per-class FIFOs.
//
//  channel  | ports                              | direction
//  ---------+------------------------------------+----------
//  request  | req_valid, req_stall, req_payload  | in
//  response | rsp_valid, rsp_stall, rsp_payload  | out
//
// One request per cycle while req_stall is low; the response follows via the middle stage.
// Counters and pointers update at the accept edge; the FIFO head read is registered in the
// same edge and merged into the response register when the middle stage advances.
// Synchronous active-high reset empties all three classes; no clearing pass.
// A stalled response holds; one more request is taken into the middle stage,
// after which req_stall follows rsp_stall.
module three_class_call_priority_queue_unit #(
   parameter int CLASS_DEPTH = cpq_pkg::CPQ_CLASS_DEPTH,
   parameter int ID_WIDTH    = cpq_pkg::CPQ_ID_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cpq_pkg::cpq_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cpq_pkg::cpq_rsp_type rsp_payload
);
   import cpq_pkg::*;

`include "three_class_call_priority_queue_unit_assert.svh"

   localparam int PtrW  = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
   localparam int CntW  = $clog2(CLASS_DEPTH + 1);
   localparam int TotW  = CntW + 2;
   localparam int KeepW = (ID_WIDTH < CPQ_CALL_ID_W) ? ID_WIDTH : CPQ_CALL_ID_W;

   // Middle stage: everything but the served id
   typedef struct packed {
      logic                   ok;
      logic                   srv;
      logic [CPQ_CLASS_W-1:0] served_class;
      logic [CPQ_REMOVED_W-1:0] removed;
      logic [CPQ_TOTAL_W-1:0] total;
   } cpq_stage_type;

   logic [CntW-1:0]     cnt_ff [CPQ_NUM_CLASSES];
   logic [CntW-1:0]     cnt_in [CPQ_NUM_CLASSES];
   logic [PtrW-1:0]     rp_ff  [CPQ_NUM_CLASSES];
   logic [PtrW-1:0]     rp_in  [CPQ_NUM_CLASSES];
   logic [PtrW-1:0]     wp_ff  [CPQ_NUM_CLASSES];
   logic [PtrW-1:0]     wp_in  [CPQ_NUM_CLASSES];
   logic [ID_WIDTH-1:0] rd_ff  [CPQ_NUM_CLASSES];
   logic [CPQ_NUM_CLASSES-1:0] app_hit;
   logic [CPQ_NUM_CLASSES-1:0] srv_hit;
   logic [CPQ_NUM_CLASSES-1:0] dis_hit;

   logic                   accept;
   logic                   is_app;
   logic                   is_srv;
   logic                   is_dis;
   logic                   srv_ok;
   logic [CPQ_CLASS_W-1:0] srv_cls;
   logic [CPQ_CLASS_W-1:0] dis_cls;
   logic [CntW-1:0]        dis_cnt;
   logic [TotW-1:0]        total_sum;
   logic [ID_WIDTH-1:0]    id_wr;
   logic [ID_WIDTH-1:0]    rd_sel;
   logic                   counts_ok;

   cpq_stage_type a_ff;
   cpq_stage_type a_in;
   logic          a_valid_ff;
   logic          a_valid_in;
   logic          a_adv;
   cpq_rsp_type   rsp_ff;
   cpq_rsp_type   rsp_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;

   // Handshake
   assign a_adv     = a_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = a_valid_ff && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Request decode and class selection
   assign is_app  = (req_payload.req_type == CPQ_REQ_APPEND);
   assign is_srv  = (req_payload.req_type == CPQ_REQ_SERVE);
   assign is_dis  = (req_payload.req_type == CPQ_REQ_DISMISS);
   assign srv_ok  = (cnt_ff[0] != '0) || (cnt_ff[1] != '0) || (cnt_ff[2] != '0);
   assign srv_cls = (cnt_ff[2] != '0) ? CPQ_CLS_EMERG :
                    (cnt_ff[1] != '0) ? CPQ_CLS_VOICE : CPQ_CLS_DATA;
   assign dis_cls = (cnt_ff[0] != '0) ? CPQ_CLS_DATA : CPQ_CLS_VOICE;
   assign dis_cnt = (cnt_ff[0] != '0) ? cnt_ff[0] : cnt_ff[1];
   assign id_wr   = ID_WIDTH'(req_payload.call_id[KeepW-1:0]);

   // Per-class counter and pointer updates
   always_comb begin
      for (int c = 0; c < CPQ_NUM_CLASSES; c++) begin
         app_hit[c] = accept && is_app && (req_payload.call_class == CPQ_CLASS_W'(c))
                      && (cnt_ff[c] != CntW'(CLASS_DEPTH));
         srv_hit[c] = accept && is_srv && srv_ok && (srv_cls == CPQ_CLASS_W'(c));
         dis_hit[c] = accept && is_dis && (dis_cls == CPQ_CLASS_W'(c));
         cnt_in[c]  = cnt_ff[c];
         rp_in[c]   = rp_ff[c];
         wp_in[c]   = wp_ff[c];
         if (app_hit[c]) begin
            cnt_in[c] = cnt_ff[c] + CntW'(1);
            wp_in[c]  = (wp_ff[c] == PtrW'(CLASS_DEPTH - 1)) ? '0 : wp_ff[c] + PtrW'(1);
         end else if (srv_hit[c]) begin
            cnt_in[c] = cnt_ff[c] - CntW'(1);
            rp_in[c]  = (rp_ff[c] == PtrW'(CLASS_DEPTH - 1)) ? '0 : rp_ff[c] + PtrW'(1);
         end else if (dis_hit[c]) begin
            cnt_in[c] = '0;
            rp_in[c]  = wp_ff[c];
         end
      end
   end

   assign total_sum = TotW'(cnt_in[0]) + TotW'(cnt_in[1]) + TotW'(cnt_in[2]);

   // Middle stage contents
   always_comb begin
      a_in              = '0;
      a_in.ok           = (is_app && (app_hit != '0)) || (is_srv && srv_ok) || is_dis;
      a_in.srv          = is_srv && srv_ok;
      a_in.served_class = (is_srv && srv_ok) ? srv_cls : CPQ_CLS_DATA;
      a_in.removed      = is_dis ? CPQ_REMOVED_W'(dis_cnt) : '0;
      a_in.total        = CPQ_TOTAL_W'(total_sum);
   end

   assign a_valid_in = accept ? 1'b1 : (a_adv ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         for (int c = 0; c < CPQ_NUM_CLASSES; c++) begin
            cnt_ff[c] <= '0;
            rp_ff[c]  <= '0;
            wp_ff[c]  <= '0;
         end
      end else begin
         a_valid_ff <= a_valid_in;
         for (int c = 0; c < CPQ_NUM_CLASSES; c++) begin
            cnt_ff[c] <= cnt_in[c];
            rp_ff[c]  <= rp_in[c];
            wp_ff[c]  <= wp_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff <= a_in;
      end
   end

   // Class FIFO storage: write at tail, registered read of head
   for (genvar g = 0; g < CPQ_NUM_CLASSES; g++) begin : g_class
      logic [ID_WIDTH-1:0] mem [CLASS_DEPTH];

      always_ff @(posedge clock) begin
         if (app_hit[g]) begin
            mem[wp_ff[g]] <= id_wr;
         end
         if (accept) begin
            rd_ff[g] <= mem[rp_ff[g]];
         end
      end
   end

   // Pick the head word of the served class
   always_comb begin
      case (a_ff.served_class)
         CPQ_CLS_DATA:  rd_sel = rd_ff[0];
         CPQ_CLS_VOICE: rd_sel = rd_ff[1];
         CPQ_CLS_EMERG: rd_sel = rd_ff[2];
         default:       rd_sel = '0;
      endcase
   end

   // Response register
   always_comb begin
      rsp_in               = '0;
      rsp_in.ok            = a_ff.ok;
      rsp_in.served_id     = a_ff.srv ? CPQ_CALL_ID_W'(rd_sel[KeepW-1:0]) : '0;
      rsp_in.served_class  = a_ff.served_class;
      rsp_in.removed_count = a_ff.removed;
      rsp_in.total_count   = a_ff.total;
   end

   assign rsp_valid_in = a_adv ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Every class count stays within its store
   assign counts_ok = (cnt_ff[0] <= CntW'(CLASS_DEPTH)) && (cnt_ff[1] <= CntW'(CLASS_DEPTH))
                      && (cnt_ff[2] <= CntW'(CLASS_DEPTH));

   // Checks
   `CPQ_ASSERT_NEXT(a_accept_fills_stage, accept, a_valid_ff)
   `CPQ_ASSERT_NEXT(a_stage_holds, a_valid_ff && !a_adv, a_valid_ff && $stable(a_ff))
   `CPQ_ASSERT_NOW(a_counts_bounded, 1'b1, counts_ok)

endmodule
